/* hdl/slcd_pkg.sv */
// Package for the segment LCD character writer: command codes, glyph and
// position tables, pixel remap tables and the queue entry type.
// Depends on nothing.
package slcd_pkg;

   typedef enum logic [3:0] {
      CMD_CHAR      = 4'd0,
      CMD_SET_PIX   = 4'd1,
      CMD_CLR_PIX   = 4'd2,
      CMD_SET_IND   = 4'd3,
      CMD_CLR_IND   = 4'd4,
      CMD_CLR_INDS  = 4'd5,
      CMD_SET_COLON = 4'd6,
      CMD_CLR_COLON = 4'd7,
      CMD_ROW       = 4'd8,
      CMD_CLEAR     = 4'd9
   } cmd_type;

   localparam int unsigned GLYPH_POSITIONS = 10;
   localparam int unsigned NUM_COMS = 3;
   localparam int unsigned LOW_W = 32;
   localparam int unsigned HIGH_W = 12;
   localparam int unsigned LINE_W = LOW_W + HIGH_W;
   localparam int unsigned FIRST_PRINTABLE = 32;
   localparam int unsigned LAST_PRINTABLE = 126;
   localparam int unsigned MAX_GLASS_SEG = 23;
   localparam int unsigned NINTH_SEG = 15;
   localparam int unsigned NUM_IND = 5;
   localparam int unsigned QUEUE_DEPTH = 2;

   // One pixel operation: write enable mask and value per common, all lines.
   typedef struct packed {
      logic [NUM_COMS-1:0][LINE_W-1:0] mask;
      logic [NUM_COMS-1:0][LINE_W-1:0] value;
      logic [NUM_COMS-1:0]             row_write;
      logic                            clear_all;
      logic                            error;
      logic                            update;
   } op_type;

   function automatic logic [7:0] glyph_bits(input logic [6:0] idx);
      logic [7:0] g;
      unique case (idx)
         7'd0: g=8'h00; 7'd1: g=8'h60; 7'd2: g=8'h22; 7'd3: g=8'h63;
         7'd4: g=8'h2D; 7'd5: g=8'h00; 7'd6: g=8'h44; 7'd7: g=8'h20;
         7'd8: g=8'h39; 7'd9: g=8'h0F; 7'd10: g=8'hC0; 7'd11: g=8'h70;
         7'd12: g=8'h04; 7'd13: g=8'h40; 7'd14: g=8'h40; 7'd15: g=8'h12;
         7'd16: g=8'h3F; 7'd17: g=8'h06; 7'd18: g=8'h5B; 7'd19: g=8'h4F;
         7'd20: g=8'h66; 7'd21: g=8'h6D; 7'd22: g=8'h7D; 7'd23: g=8'h07;
         7'd24: g=8'h7F; 7'd25: g=8'h6F; 7'd26: g=8'h00; 7'd27: g=8'h00;
         7'd28: g=8'h58; 7'd29: g=8'h48; 7'd30: g=8'h4C; 7'd31: g=8'h53;
         7'd32: g=8'hFF; 7'd33: g=8'h77; 7'd34: g=8'h7F; 7'd35: g=8'h39;
         7'd36: g=8'h3F; 7'd37: g=8'h79; 7'd38: g=8'h71; 7'd39: g=8'h3D;
         7'd40: g=8'h76; 7'd41: g=8'h89; 7'd42: g=8'h0E; 7'd43: g=8'h75;
         7'd44: g=8'h38; 7'd45: g=8'hB7; 7'd46: g=8'h37; 7'd47: g=8'h3F;
         7'd48: g=8'h73; 7'd49: g=8'h67; 7'd50: g=8'hF7; 7'd51: g=8'h6D;
         7'd52: g=8'h81; 7'd53: g=8'h3E; 7'd54: g=8'h3E; 7'd55: g=8'hBE;
         7'd56: g=8'h7E; 7'd57: g=8'h6E; 7'd58: g=8'h1B; 7'd59: g=8'h39;
         7'd60: g=8'h24; 7'd61: g=8'h0F; 7'd62: g=8'h23; 7'd63: g=8'h08;
         7'd64: g=8'h02; 7'd65: g=8'h5F; 7'd66: g=8'h7C; 7'd67: g=8'h58;
         7'd68: g=8'h5E; 7'd69: g=8'h7B; 7'd70: g=8'h71; 7'd71: g=8'h6F;
         7'd72: g=8'h74; 7'd73: g=8'h10; 7'd74: g=8'h42; 7'd75: g=8'h75;
         7'd76: g=8'h30; 7'd77: g=8'hB7; 7'd78: g=8'h54; 7'd79: g=8'h5C;
         7'd80: g=8'h73; 7'd81: g=8'h67; 7'd82: g=8'h50; 7'd83: g=8'h6D;
         7'd84: g=8'h78; 7'd85: g=8'h62; 7'd86: g=8'h1C; 7'd87: g=8'hBE;
         7'd88: g=8'h7E; 7'd89: g=8'h6E; 7'd90: g=8'h1B; 7'd91: g=8'h16;
         7'd92: g=8'h36; 7'd93: g=8'h34; 7'd94: g=8'h01;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

   // Byte i of a position map: common in bits 7:6, glass segment in 5:0.
   function automatic logic [63:0] pos_map(input logic [3:0] pos);
      logic [63:0] m;
      unique case (pos)
         4'd0: m = 64'h4e4f0e8e8f8d4d0d;
         4'd1: m = 64'h0c8c4c4c8b4b4b0b;
         4'd2: m = 64'hc049c00a49890949;
         4'd3: m = 64'hc048088886874707;
         4'd4: m = 64'hc053921252139352;
         4'd5: m = 64'hc054511415559594;
         4'd6: m = 64'hc057965616179716;
         4'd7: m = 64'hc041804000018a81;
         4'd8: m = 64'hc043420203048382;
         4'd9: m = 64'hc045440506468584;
         default: m = '1;
      endcase
      return m;
   endfunction

   function automatic logic [5:0] line_of_seg(input logic [4:0] seg);
      logic [5:0] l;
      unique case (seg)
         5'd0: l=6'd12; 5'd1: l=6'd24; 5'd2: l=6'd17; 5'd3: l=6'd40;
         5'd4: l=6'd41; 5'd5: l=6'd42; 5'd6: l=6'd7; 5'd7: l=6'd8;
         5'd8: l=6'd9; 5'd9: l=6'd6; 5'd10: l=6'd21; 5'd11: l=6'd11;
         5'd12: l=6'd10; 5'd13: l=6'd23; 5'd14: l=6'd22; 5'd15: l=6'd4;
         5'd16: l=6'd3; 5'd17: l=6'd5; 5'd18: l=6'd2; 5'd19: l=6'd18;
         5'd20: l=6'd19; 5'd21: l=6'd20; 5'd22: l=6'd0; 5'd23: l=6'd1;
         default: l = 6'd0;
      endcase
      return l;
   endfunction

   function automatic logic [1:0] ind_com(input logic [2:0] ind);
      logic [1:0] c;
      unique case (ind)
         3'd0, 3'd1: c = 2'd0;
         3'd2, 3'd3: c = 2'd2;
         3'd4:       c = 2'd1;
         default:    c = 2'd3;
      endcase
      return c;
   endfunction

   function automatic logic [5:0] ind_seg(input logic [2:0] ind);
      logic [5:0] s;
      unique case (ind)
         3'd0, 3'd2: s = 6'd17;
         3'd1, 3'd3: s = 6'd16;
         3'd4:       s = 6'd10;
         default:    s = 6'd63;
      endcase
      return s;
   endfunction

endpackage

/* hdl/slcd_front.sv */
// Front end: classifies one command into a per-common mask and value.
// Depends on slcd_pkg.
module slcd_front #(
   parameter int unsigned GLYPH_POSITIONS = slcd_pkg::GLYPH_POSITIONS
) (
   input  logic [3:0]        cmd,
   input  logic [7:0]        character,
   input  logic [3:0]        position,
   input  logic [1:0]        com,
   input  logic [5:0]        seg,
   input  logic [2:0]        indicator,
   output slcd_pkg::op_type  op
);

   // Applies one pixel write to the operation; later writes override.
   function automatic slcd_pkg::op_type put(input slcd_pkg::op_type o_in,
                                            input logic [1:0] c,
                                            input logic [5:0] s,
                                            input logic on);
      slcd_pkg::op_type o;
      logic [5:0] ln;
      o = o_in;
      ln = slcd_pkg::line_of_seg(s[4:0]);
      if (c <= 2'd2 && s <= 6'(slcd_pkg::MAX_GLASS_SEG)) begin
         o.mask[c][ln]  = 1'b1;
         o.value[c][ln] = on;
      end
      return o;
   endfunction

   logic [7:0]  ch;
   logic [7:0]  bits;
   logic [63:0] map;
   logic [7:0]  entry;

   assign ch = (character < 8'(slcd_pkg::FIRST_PRINTABLE)
                || character > 8'(slcd_pkg::LAST_PRINTABLE))
               ? 8'(slcd_pkg::FIRST_PRINTABLE) : character;
   assign bits = slcd_pkg::glyph_bits(7'(ch - 8'(slcd_pkg::FIRST_PRINTABLE)));
   assign map = slcd_pkg::pos_map(position);

   // Build the mask and value for the command.
   always_comb begin
      op = '0;
      entry = '0;
      unique case (cmd)
         slcd_pkg::CMD_CHAR: begin
            if (32'(position) < GLYPH_POSITIONS && position <= 4'd9) begin
               if (position == 4'd0)
                  op = put(op, 2'd0, 6'(slcd_pkg::NINTH_SEG), 1'b0);
               for (int i = 0; i < 8; i++) begin
                  entry = map[8*i +: 8];
                  op = put(op, entry[7:6], entry[5:0], bits[i]);
               end
               if (position == 4'd0 && (ch == 8'h42 || ch == 8'h44 || ch == 8'h40))
                  op = put(op, 2'd0, 6'(slcd_pkg::NINTH_SEG), 1'b1);
            end
         end
         slcd_pkg::CMD_SET_PIX: op = put(op, com, seg, 1'b1);
         slcd_pkg::CMD_CLR_PIX: op = put(op, com, seg, 1'b0);
         slcd_pkg::CMD_SET_IND:
            op = put(op, slcd_pkg::ind_com(indicator), slcd_pkg::ind_seg(indicator), 1'b1);
         slcd_pkg::CMD_CLR_IND:
            op = put(op, slcd_pkg::ind_com(indicator), slcd_pkg::ind_seg(indicator), 1'b0);
         slcd_pkg::CMD_CLR_INDS: begin
            for (int i = 0; i < slcd_pkg::NUM_IND; i++)
               op = put(op, slcd_pkg::ind_com(3'(i)), slcd_pkg::ind_seg(3'(i)), 1'b0);
         end
         slcd_pkg::CMD_SET_COLON: op = put(op, 2'd1, 6'd16, 1'b1);
         slcd_pkg::CMD_CLR_COLON: op = put(op, 2'd1, 6'd16, 1'b0);
         slcd_pkg::CMD_ROW: begin
            if (com == 2'd3) op.error = 1'b1;
            else op.row_write[com] = 1'b1;
         end
         slcd_pkg::CMD_CLEAR: begin
            op.clear_all = 1'b1;
            op.update = 1'b1;
         end
         default: op = '0;
      endcase
   end

endmodule

/* hdl/slcd_back.sv */
// Back end: holds the display RAM, applies queued operations and presents
// the whole RAM on a registered result stage. Depends on slcd_pkg.
module slcd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      op_valid,
   output logic                      op_ready,
   input  slcd_pkg::op_type          op,
   input  logic [slcd_pkg::LINE_W-1:0] row,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [slcd_pkg::NUM_COMS-1:0][slcd_pkg::LINE_W-1:0] ram,
   output logic                      error,
   output logic                      update
);

   logic [slcd_pkg::NUM_COMS-1:0][slcd_pkg::LINE_W-1:0] ram_ff, ram_in;
   logic valid_ff, valid_in;
   logic err_ff, err_in, upd_ff, upd_in;

   // The result register takes a new op whenever it is empty or drained.
   assign op_ready = !valid_ff || out_ready;

   always_comb begin
      ram_in = ram_ff;
      valid_in = valid_ff && !out_ready;
      err_in = err_ff;
      upd_in = upd_ff;
      if (op_valid && op_ready) begin
         valid_in = 1'b1;
         err_in = op.error;
         upd_in = op.update;
         for (int c = 0; c < slcd_pkg::NUM_COMS; c++) begin
            if (op.clear_all) ram_in[c] = '0;
            else if (op.row_write[c]) ram_in[c] = row;
            else ram_in[c] = (ram_ff[c] & ~op.mask[c]) | (op.value[c] & op.mask[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_ff <= '0;
         valid_ff <= 1'b0;
         err_ff <= 1'b0;
         upd_ff <= 1'b0;
      end else begin
         ram_ff <= ram_in;
         valid_ff <= valid_in;
         err_ff <= err_in;
         upd_ff <= upd_in;
      end
   end

   assign out_valid = valid_ff;
   assign ram = ram_ff;
   assign error = err_ff;
   assign update = upd_ff;

endmodule

/* hdl/segment_lcd_character_writer_top.sv */
// Top level of the segment LCD character writer: front classifier, a
// two-entry queue and the display RAM back end. Depends on slcd_pkg.
//
// Usage: drive a command on the req_ channel (valid/ready). Each command
// gives exactly one rsp_ transfer carrying the whole 3 x 44 display RAM
// after the command, plus error (row write to common 3) and
// update_request (clear display).
// A command is written into the queue register when it is accepted; the
// back end registers its result as it leaves the queue, valid in the cycle
// after. Throughput: one command per cycle while the receiver takes every
// result, set by the read-modify-write of the RAM registers.
// Reset clears the RAM to zero and empties the queue and result register.
// When the receiver stalls, the result holds, the queue fills with up to
// two commands, and then req_ready drops until results are taken.
module segment_lcd_character_writer_top #(
   parameter int unsigned GLYPH_POSITIONS = slcd_pkg::GLYPH_POSITIONS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_cmd,
   input  logic [7:0]  req_character,
   input  logic [3:0]  req_position,
   input  logic [1:0]  req_com,
   input  logic [5:0]  req_seg,
   input  logic [2:0]  req_indicator,
   input  logic [31:0] req_row_low,
   input  logic [11:0] req_row_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_com0_low,
   output logic [11:0] rsp_com0_high,
   output logic [31:0] rsp_com1_low,
   output logic [11:0] rsp_com1_high,
   output logic [31:0] rsp_com2_low,
   output logic [11:0] rsp_com2_high,
   output logic        rsp_error,
   output logic        rsp_update_request
);

   localparam int unsigned QD = slcd_pkg::QUEUE_DEPTH;

   slcd_pkg::op_type fr_op;
   slcd_pkg::op_type q_op_ff [QD];
   logic [slcd_pkg::LINE_W-1:0] q_row_ff [QD];
   logic [$clog2(QD)-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [$clog2(QD):0]   cnt_ff, cnt_in;
   logic op_ready;
   logic [slcd_pkg::NUM_COMS-1:0][slcd_pkg::LINE_W-1:0] ram;
   logic push, pop;

   slcd_front #(.GLYPH_POSITIONS(GLYPH_POSITIONS)) u_front (
      .cmd(req_cmd), .character(req_character), .position(req_position),
      .com(req_com), .seg(req_seg), .indicator(req_indicator), .op(fr_op)
   );

   // Queue between front and back.
   assign req_ready = cnt_ff != ($clog2(QD)+1)'(QD);
   assign push = req_valid && req_ready;
   assign pop = cnt_ff != '0 && op_ready;
   assign wr_in = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in = pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + ($clog2(QD)+1)'(push) - ($clog2(QD)+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_op_ff[wr_ff] <= fr_op;
         q_row_ff[wr_ff] <= {req_row_high, req_row_low};
      end
   end

   slcd_back u_back (
      .clock(clock), .reset(reset),
      .op_valid(cnt_ff != '0), .op_ready(op_ready),
      .op(q_op_ff[rd_ff]), .row(q_row_ff[rd_ff]),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .ram(ram), .error(rsp_error), .update(rsp_update_request)
   );

   assign rsp_com0_low  = ram[0][31:0];
   assign rsp_com0_high = ram[0][43:32];
   assign rsp_com1_low  = ram[1][31:0];
   assign rsp_com1_high = ram[1][43:32];
   assign rsp_com2_low  = ram[2][31:0];
   assign rsp_com2_high = ram[2][43:32];

   // The queue never overflows or underflows.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ($clog2(QD)+1)'(QD)) else $error("queue count out of range");
   // A result with update_request shows an empty display.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_update_request |-> ram == '0)
      else $error("clear left RAM bits set");
   // error and update_request never show together.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_error && rsp_update_request))
      else $error("error and update both set");

endmodule
